>>> rtl/fmsp_pkg.sv
// Shared types, codes and constant tables of the file mode string parser.
package fmsp_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Sticky letter t is part of the accepted grammar.
   localparam logic STICKY_SUPPORTED = 1'b1;

   localparam logic [11:0] UMASK_RESET = 12'o0022;
   localparam logic [11:0] PERM_ALL    = 12'o7777;
   localparam logic [15:0] TYPE_MASK   = 16'o170000;
   localparam logic [15:0] TYPE_DIR    = 16'o040000;
   localparam logic [11:0] EXEC_BITS   = 12'o0111;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_CHAR  = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_FIRST,
      PH_NUM,
      PH_WHO,
      PH_OPSTART,
      PH_PERMS,
      PH_COPIED
   } phase_type;

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_WHO,
      CLS_OP,
      CLS_PERM,
      CLS_PERM_X,
      CLS_COMMA,
      CLS_OTHER
   } cls_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_ADD,
      OP_SUB,
      OP_SET
   } op_type;

   typedef enum logic [1:0] {
      WHO_U,
      WHO_G,
      WHO_O,
      WHO_A
   } who_type;

   localparam logic [11:0] WHO_MASK [4] = '{12'o4700, 12'o2070, 12'o0007, 12'o6777};
   localparam logic [11:0] COPY_MASK [5] =
      '{12'o0444, 12'o0222, 12'o0111, 12'o6000, 12'o1000};

   // One classified word as it travels from the front end to the parser.
   typedef struct packed {
      logic          kind;
      logic          last;
      logic [15:0]   initial_mode;
      cls_type       cls;
      logic [2:0]    digit;
      who_type       who;
      op_type        op;
      logic [11:0]   perm;
   } token_type;

endpackage

>>> rtl/fmsp_front.sv
// Front end: takes input words and classifies each character into a token.
module fmsp_front
   import fmsp_pkg::*;
(
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_kind,
   input  logic [15:0]  req_initial_mode,
   input  logic [7:0]   req_char_code,
   input  logic         req_last,
   input  logic         queue_full,
   output logic         push,
   output token_type    push_token
);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6f;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_EQUAL = 8'h3d;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_BIG_X = 8'h58;
   localparam logic [7:0] CH_COMMA = 8'h2c;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_token              = '0;
      push_token.kind         = req_kind;
      push_token.last         = req_last;
      push_token.initial_mode = req_initial_mode;
      push_token.cls          = CLS_OTHER;
      push_token.digit        = req_char_code[2:0];
      push_token.who          = WHO_U;
      push_token.op           = OP_NONE;
      push_token.perm         = '0;
      if (req_char_code inside {[CH_ZERO:CH_SEVEN]}) begin
         push_token.cls = CLS_DIGIT;
      end else begin
         case (req_char_code)
            CH_U:     begin push_token.cls = CLS_WHO; push_token.who = WHO_U; end
            CH_G:     begin push_token.cls = CLS_WHO; push_token.who = WHO_G; end
            CH_O:     begin push_token.cls = CLS_WHO; push_token.who = WHO_O; end
            CH_A:     begin push_token.cls = CLS_WHO; push_token.who = WHO_A; end
            CH_PLUS:  begin push_token.cls = CLS_OP; push_token.op = OP_ADD; end
            CH_MINUS: begin push_token.cls = CLS_OP; push_token.op = OP_SUB; end
            CH_EQUAL: begin push_token.cls = CLS_OP; push_token.op = OP_SET; end
            CH_R:     begin push_token.cls = CLS_PERM; push_token.perm = COPY_MASK[0]; end
            CH_W:     begin push_token.cls = CLS_PERM; push_token.perm = COPY_MASK[1]; end
            CH_X:     begin push_token.cls = CLS_PERM; push_token.perm = COPY_MASK[2]; end
            CH_S:     begin push_token.cls = CLS_PERM; push_token.perm = COPY_MASK[3]; end
            CH_T: begin
               if (STICKY_SUPPORTED) begin
                  push_token.cls  = CLS_PERM;
                  push_token.perm = COPY_MASK[4];
               end
            end
            CH_BIG_X: push_token.cls = CLS_PERM_X;
            CH_COMMA: push_token.cls = CLS_COMMA;
            default:  push_token.cls = CLS_OTHER;
         endcase
      end
   end

endmodule

>>> rtl/fmsp_queue.sv
// Short token queue between the front end and the parser.
module fmsp_queue
   import fmsp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  token_type   push_token,
   input  logic        pop,
   output logic        head_valid,
   output token_type   head_token,
   output logic        full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   token_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_token = entry_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_token;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("token queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !pop)
      else $error("token popped from empty queue");

endmodule

>>> rtl/fmsp_back.sv
// Parser back end: runs the mode string grammar on tokens and holds the result word.
module fmsp_back
   import fmsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [11:0]  umask,
   input  logic         head_valid,
   input  token_type    head_token,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [15:0]  rsp_final_mode,
   output logic         rsp_status
);

   phase_type     phase_ff, phase_in;
   logic [15:0]   working_ff, working_in;
   logic [15:0]   saved_ff, saved_in;
   logic [11:0]   octal_ff, octal_in;
   logic [11:0]   who_ff, who_in;
   logic          named_ff, named_in;
   op_type        op_ff, op_in;
   logic [11:0]   perm_ff, perm_in;
   logic          err_ff, err_in;

   logic          out_valid_ff, out_valid_in;
   logic [15:0]   out_mode_ff;
   logic          out_status_ff;

   logic          emit;
   logic [15:0]   emit_mode;
   logic          emit_status;
   logic [14:0]   octal_next;
   logic          exec_cond;

   function automatic logic [15:0] apply_group(input logic [15:0] mode,
                                               input logic        named,
                                               input logic [11:0] who_bits,
                                               input logic [11:0] mask,
                                               input op_type      op,
                                               input logic [11:0] perm);
      logic [11:0] who;
      logic [11:0] p;
      logic [15:0] m;
      who = named ? who_bits : (~mask & PERM_ALL);
      p   = perm & who;
      m   = mode;
      if (op == OP_SET) begin
         m = named ? (m & ~{4'b0000, who_bits}) : (m & TYPE_MASK);
      end
      if (op == OP_ADD || op == OP_SET) begin
         m = m | {4'b0000, p};
      end else if (op == OP_SUB) begin
         m = m & ~{4'b0000, p};
      end
      return m;
   endfunction

   // A copy letter takes each permission class that has any bit set in the source.
   function automatic logic [11:0] copy_bits(input logic [15:0] mode, input who_type who);
      logic [11:0] src;
      logic [11:0] res;
      src = mode[11:0] & WHO_MASK[who];
      res = '0;
      for (int k = 0; k < 5; k++) begin
         if ((src & COPY_MASK[k]) != '0) begin
            res = res | COPY_MASK[k];
         end
      end
      return res;
   endfunction

   assign pop        = head_valid && (!out_valid_ff || !rsp_stall);
   assign octal_next = {octal_ff, 3'b000} + 15'(head_token.digit);
   assign exec_cond  = ((working_ff[11:0] & EXEC_BITS) != '0)
                       || ((working_ff & TYPE_MASK) == TYPE_DIR);

   always_comb begin
      phase_in    = phase_ff;
      working_in  = working_ff;
      saved_in    = saved_ff;
      octal_in    = octal_ff;
      who_in      = who_ff;
      named_in    = named_ff;
      op_in       = op_ff;
      perm_in     = perm_ff;
      err_in      = err_ff;
      emit        = 1'b0;
      emit_mode   = saved_ff;
      emit_status = 1'b1;
      if (pop) begin
         if (head_token.kind == KIND_START) begin
            saved_in   = head_token.initial_mode;
            working_in = head_token.initial_mode;
            octal_in   = '0;
            who_in     = '0;
            named_in   = 1'b0;
            op_in      = OP_NONE;
            perm_in    = '0;
            err_in     = 1'b0;
            if (head_token.last) begin
               // An empty string is malformed.
               phase_in    = PH_IDLE;
               emit        = 1'b1;
               emit_mode   = head_token.initial_mode;
               emit_status = 1'b1;
            end else begin
               phase_in = PH_FIRST;
            end
         end else if (phase_ff != PH_IDLE) begin
            if (!err_ff) begin
               if (phase_ff == PH_FIRST && head_token.cls == CLS_DIGIT) begin
                  octal_in = {9'b0, head_token.digit};
                  phase_in = PH_NUM;
               end else begin
                  if (phase_ff == PH_FIRST) begin
                     who_in   = '0;
                     named_in = 1'b0;
                     phase_in = PH_WHO;
                  end
                  case (phase_in)
                     PH_NUM: begin
                        if (head_token.cls != CLS_DIGIT) begin
                           err_in = 1'b1;
                        end else if (octal_next > 15'(PERM_ALL)) begin
                           err_in = 1'b1;
                        end else begin
                           octal_in = octal_next[11:0];
                        end
                     end
                     PH_WHO: begin
                        if (head_token.cls == CLS_WHO) begin
                           who_in   = who_ff | WHO_MASK[head_token.who];
                           named_in = 1'b1;
                           if (phase_ff == PH_FIRST) begin
                              who_in = WHO_MASK[head_token.who];
                           end
                        end else if (head_token.cls == CLS_OP) begin
                           op_in    = head_token.op;
                           perm_in  = '0;
                           phase_in = PH_OPSTART;
                        end else begin
                           err_in = 1'b1;
                        end
                     end
                     PH_OPSTART, PH_PERMS, PH_COPIED: begin
                        if (phase_in == PH_OPSTART && head_token.cls == CLS_WHO
                            && head_token.who != WHO_A) begin
                           perm_in  = perm_ff | copy_bits(working_ff, head_token.who);
                           phase_in = PH_COPIED;
                        end else if (phase_in != PH_COPIED && head_token.cls == CLS_PERM) begin
                           perm_in  = perm_ff | head_token.perm;
                           phase_in = PH_PERMS;
                        end else if (phase_in != PH_COPIED
                                     && head_token.cls == CLS_PERM_X) begin
                           if (exec_cond) begin
                              perm_in = perm_ff | EXEC_BITS;
                           end
                           phase_in = PH_PERMS;
                        end else if (head_token.cls == CLS_OP) begin
                           working_in = apply_group(working_ff, named_ff, who_ff, umask,
                                                    op_ff, perm_ff);
                           op_in      = head_token.op;
                           perm_in    = '0;
                           phase_in   = PH_OPSTART;
                        end else if (head_token.cls == CLS_COMMA) begin
                           working_in = apply_group(working_ff, named_ff, who_ff, umask,
                                                    op_ff, perm_ff);
                           op_in      = OP_NONE;
                           perm_in    = '0;
                           who_in     = '0;
                           named_in   = 1'b0;
                           phase_in   = PH_WHO;
                        end else begin
                           err_in = 1'b1;
                        end
                     end
                     default: err_in = 1'b1;
                  endcase
               end
            end
            if (head_token.last) begin
               // Closing word: finish the open group or number, or flag a dangling clause.
               emit        = 1'b1;
               emit_status = err_in;
               emit_mode   = working_in;
               if (!err_in) begin
                  if (phase_in == PH_NUM) begin
                     emit_mode = {saved_ff[15:12], octal_in};
                  end else if (phase_in == PH_OPSTART || phase_in == PH_PERMS
                               || phase_in == PH_COPIED) begin
                     working_in = apply_group(working_in, named_in, who_in, umask,
                                              op_in, perm_in);
                     emit_mode  = working_in;
                     op_in      = OP_NONE;
                     perm_in    = '0;
                  end else begin
                     emit_status = 1'b1;
                  end
               end
               if (emit_status) begin
                  emit_mode = saved_ff;
               end
               phase_in = PH_IDLE;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         working_ff   <= '0;
         saved_ff     <= '0;
         octal_ff     <= '0;
         who_ff       <= '0;
         named_ff     <= 1'b0;
         op_ff        <= OP_NONE;
         perm_ff      <= '0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         working_ff   <= working_in;
         saved_ff     <= saved_in;
         octal_ff     <= octal_in;
         who_ff       <= who_in;
         named_ff     <= named_in;
         op_ff        <= op_in;
         perm_ff      <= perm_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_mode_ff   <= emit_mode;
         out_status_ff <= emit_status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_final_mode = out_mode_ff;
   assign rsp_status     = out_status_ff;

   a_octal_bound: assert property (@(posedge clock) disable iff (reset)
      octal_ff <= PERM_ALL)
      else $error("octal value above the permission range");

   a_held_blocks_pop: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !pop)
      else $error("token consumed while result word is held");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_IDLE && !out_valid_ff))
      else $error("parser not idle after reset");

endmodule

>>> rtl/file_mode_string_parser_core.sv
// Top level of the file mode string parser: umask register, front end, queue and parser.
// rsp_valid rises once the last word has passed through the token queue and then the
// result register, and a held result word can keep it waiting in the queue. The parser
// consumes one queued token per cycle, so one word per cycle is sustained while the result
// side takes words. While a result word is held, up to QUEUE_DEPTH words are still accepted.
// Reset (synchronous, active high) empties the queue, drops any result word, returns the
// parser to awaiting a start word and sets the umask to 022.
module file_mode_string_parser_core
   import fmsp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [11:0]  csr_write_data,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_kind,
   input  logic [15:0]  req_initial_mode,
   input  logic [7:0]   req_char_code,
   input  logic         req_last,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [15:0]  rsp_final_mode,
   output logic         rsp_status
);

   logic [11:0]   umask_ff, umask_in;
   logic          push;
   token_type     push_token;
   logic          pop;
   logic          head_valid;
   token_type     head_token;
   logic          queue_full;

   assign umask_in = csr_write_enable ? csr_write_data : umask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         umask_ff <= UMASK_RESET;
      end else begin
         umask_ff <= umask_in;
      end
   end

   fmsp_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_initial_mode (req_initial_mode),
      .req_char_code    (req_char_code),
      .req_last         (req_last),
      .queue_full       (queue_full),
      .push             (push),
      .push_token       (push_token)
   );

   fmsp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .head_valid (head_valid),
      .head_token (head_token),
      .full       (queue_full)
   );

   fmsp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .umask          (umask_ff),
      .head_valid     (head_valid),
      .head_token     (head_token),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_final_mode (rsp_final_mode),
      .rsp_status     (rsp_status)
   );

endmodule

>>> bench/tb_top.sv
// Self-checking testbench of the file mode string parser core.
module tb_top
   import fmsp_pkg::*;
();

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 300;

   typedef struct {
      logic [15:0] final_mode;
      logic        status;
   } mode_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [11:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_START;
   logic [15:0] req_initial_mode = '0;
   logic [7:0]  req_char_code = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_final_mode;
   logic        rsp_status;

   // Evaluator state, kept in step with every word the block accepts.
   phase_type   ev_phase;
   logic [15:0] ev_mode;
   logic [15:0] ev_saved_mode;
   logic [12:0] ev_octal;
   logic [11:0] ev_who_bits;
   logic        ev_who_named;
   op_type      ev_op;
   logic [11:0] ev_perm;
   logic        ev_error;
   logic [11:0] ev_umask;

   mode_result_type pending_modes[$];
   logic [7:0]      text_buf[$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   bit stall_hold_request = 1'b0;

   file_mode_string_parser_core u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_initial_mode (req_initial_mode),
      .req_char_code    (req_char_code),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_final_mode   (rsp_final_mode),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("file_mode_string_parser_core: mismatch");
         $finish;
      end
   end

   // Result side: random stalls, or one long hold-off when it is requested.
   always @(posedge clock) begin
      if (stall_hold_request) begin
         hold_left = HOLD_CYCLES;
         stall_hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_result
      mode_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_modes.size() == 0) begin
            $error("result word with none expected: final_mode %o status %0d",
                   rsp_final_mode, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_modes.pop_front();
            if (rsp_final_mode !== want.final_mode) begin
               $error("final_mode: expected %o, actual %o", want.final_mode, rsp_final_mode);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   function automatic op_type op_of(logic [7:0] c);
      case (c)
         "+": return OP_ADD;
         "-": return OP_SUB;
         "=": return OP_SET;
         default: return OP_NONE;
      endcase
   endfunction

   function automatic int who_of(logic [7:0] c);
      case (c)
         "u": return int'(WHO_U);
         "g": return int'(WHO_G);
         "o": return int'(WHO_O);
         "a": return int'(WHO_A);
         default: return -1;
      endcase
   endfunction

   function automatic void start_clause();
      ev_who_bits = '0;
      ev_who_named = 1'b0;
      ev_phase = PH_WHO;
   endfunction

   // Adds the bits of a permission letter; false when the letter is not one.
   function automatic bit perm_letter(logic [7:0] c);
      case (c)
         "r": begin
            ev_perm |= 12'o0444;
            return 1'b1;
         end
         "w": begin
            ev_perm |= 12'o0222;
            return 1'b1;
         end
         "x": begin
            ev_perm |= EXEC_BITS;
            return 1'b1;
         end
         "s": begin
            ev_perm |= 12'o6000;
            return 1'b1;
         end
         "t": begin
            if (STICKY_SUPPORTED) begin
               ev_perm |= 12'o1000;
               return 1'b1;
            end
            return 1'b0;
         end
         "X": begin
            if ((ev_mode[11:0] & EXEC_BITS) != 0 || (ev_mode & TYPE_MASK) == TYPE_DIR)
               ev_perm |= EXEC_BITS;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void apply_group();
      logic [11:0] who;
      logic [11:0] bits;
      who = ev_who_named ? ev_who_bits : ~ev_umask;
      bits = ev_perm & who;
      if (ev_op == OP_SET)
         ev_mode = ev_who_named ? (ev_mode & ~{4'h0, ev_who_bits}) : (ev_mode & TYPE_MASK);
      if (ev_op == OP_ADD || ev_op == OP_SET)
         ev_mode |= {4'h0, bits};
      else if (ev_op == OP_SUB)
         ev_mode &= ~{4'h0, bits};
      ev_op = OP_NONE;
      ev_perm = '0;
   endfunction

   function automatic void take_char(logic [7:0] c);
      op_type op;
      int wi;
      int v;
      logic [11:0] src;
      op = op_of(c);
      if (ev_phase == PH_FIRST) begin
         if (c >= "0" && c <= "7") begin
            ev_octal = 13'(c - "0");
            ev_phase = PH_NUM;
            return;
         end
         start_clause();
      end
      wi = who_of(c);
      case (ev_phase)
         PH_NUM: begin
            if (c >= "0" && c <= "7") begin
               v = ev_octal * 8 + (c - "0");
               if (v > PERM_ALL) ev_error = 1'b1;
               else ev_octal = 13'(v);
            end else begin
               ev_error = 1'b1;
            end
         end
         PH_WHO: begin
            if (wi >= 0) begin
               ev_who_bits |= WHO_MASK[wi];
               ev_who_named = 1'b1;
            end else if (op != OP_NONE) begin
               ev_op = op;
               ev_perm = '0;
               ev_phase = PH_OPSTART;
            end else begin
               ev_error = 1'b1;
            end
         end
         PH_OPSTART, PH_PERMS, PH_COPIED: begin
            // A copy letter is only taken straight after the operator.
            if (ev_phase == PH_OPSTART && wi >= 0 && wi < 3) begin
               src = ev_mode[11:0] & WHO_MASK[wi];
               for (int k = 0; k < 5; k++)
                  if ((src & COPY_MASK[k]) != 0) ev_perm |= COPY_MASK[k];
               ev_phase = PH_COPIED;
            end else if (ev_phase != PH_COPIED && perm_letter(c)) begin
               ev_phase = PH_PERMS;
            end else if (op != OP_NONE) begin
               apply_group();
               ev_op = op;
               ev_phase = PH_OPSTART;
            end else if (c == ",") begin
               apply_group();
               start_clause();
            end else begin
               ev_error = 1'b1;
            end
         end
         default: ev_error = 1'b1;
      endcase
   endfunction

   function automatic void evaluate_word(logic kind, logic [15:0] mode, logic [7:0] ch,
                                         logic last);
      mode_result_type res;
      if (kind == KIND_START) begin
         ev_saved_mode = mode;
         ev_mode = mode;
         ev_octal = '0;
         ev_who_bits = '0;
         ev_who_named = 1'b0;
         ev_op = OP_NONE;
         ev_perm = '0;
         ev_error = 1'b0;
         ev_phase = PH_FIRST;
         if (last) begin
            ev_phase = PH_IDLE;
            res.final_mode = ev_saved_mode;
            res.status = 1'b1;
            pending_modes.push_back(res);
         end
         return;
      end
      if (ev_phase == PH_IDLE) return;
      if (!ev_error) take_char(ch);
      if (!last) return;
      res.status = ev_error;
      res.final_mode = ev_mode;
      if (!res.status) begin
         if (ev_phase == PH_NUM) begin
            res.final_mode = (ev_saved_mode & TYPE_MASK) | {4'h0, ev_octal[11:0]};
         end else if (ev_phase == PH_OPSTART || ev_phase == PH_PERMS ||
                      ev_phase == PH_COPIED) begin
            apply_group();
            res.final_mode = ev_mode;
         end else begin
            res.status = 1'b1;
         end
      end
      if (res.status) res.final_mode = ev_saved_mode;
      ev_phase = PH_IDLE;
      pending_modes.push_back(res);
   endfunction

   function automatic void build_random_text();
      string who_set = "ugoa";
      string op_set = "+-=";
      string perm_set = "rwxstX";
      string copy_set = "ugo";
      string noise_set = "ugoa+-=rwxstX,0189 ";
      int r;
      int n;
      text_buf.delete();
      r = $urandom_range(99);
      if (r < 20) begin
         n = ($urandom_range(9) == 0) ? 5 : $urandom_range(1, 4);
         repeat (n) text_buf.push_back(8'("0" + $urandom_range(7)));
      end else if (r >= 23) begin
         repeat ($urandom_range(1, 3)) begin
            if (text_buf.size() != 0) text_buf.push_back(",");
            repeat ($urandom_range(0, 3)) text_buf.push_back(who_set[$urandom_range(3)]);
            repeat ($urandom_range(1, 3)) begin
               text_buf.push_back(op_set[$urandom_range(2)]);
               if ($urandom_range(3) == 0)
                  text_buf.push_back(copy_set[$urandom_range(2)]);
               else
                  repeat ($urandom_range(0, 4)) text_buf.push_back(perm_set[$urandom_range(5)]);
            end
         end
      end
      // Some strings are broken on purpose: a stray byte, or a dangling clause.
      r = $urandom_range(99);
      if (r < 8 && text_buf.size() > 0)
         text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom);
      else if (r < 14)
         text_buf.insert($urandom_range(text_buf.size()),
                         noise_set[$urandom_range(noise_set.len() - 1)]);
      else if (r < 17)
         text_buf.push_back(",");
      else if (r < 20) begin
         text_buf.push_back(",");
         text_buf.push_back("g");
      end
   endfunction

   // Offers one word and returns at the edge that accepts it; valid is left high.
   task automatic send_word(logic kind, logic [15:0] mode, logic [7:0] ch, logic last);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_initial_mode <= mode;
      req_char_code <= ch;
      req_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      evaluate_word(kind, mode, ch, last);
   endtask

   task automatic send_buffer(logic [15:0] mode);
      int n;
      n = text_buf.size();
      send_word(KIND_START, mode, 8'($urandom), n == 0);
      for (int i = 0; i < n; i++)
         send_word(KIND_CHAR, 16'($urandom), text_buf[i], i == n - 1);
   endtask

   task automatic send_text(logic [15:0] mode, string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      send_buffer(mode);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_modes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_umask(logic [11:0] value);
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ev_umask = value;
   endtask

   task automatic test_octal_strings();
      send_text(16'hFFFF, "7777");
      send_text(16'o100644, "77777");
      send_text(16'o100644, "8");
      send_text(16'o100000, "7a");
   endtask

   task automatic test_symbolic_strings();
      send_text(TYPE_DIR, "a-x,=X");
      send_text(16'o100754, "g=u,o+t-s");
      send_text(16'o100000, "u+rw-r=");
   endtask

   task automatic test_special_cases();
      // A character word while no string is open is dropped.
      send_word(KIND_CHAR, 16'hFFFF, 8'hFF, 1'b1);
      send_text(16'o100640, "");
      // Restart in mid-string, then a clause of who letters only.
      send_word(KIND_START, 16'o100777, "u", 1'b0);
      send_word(KIND_CHAR, 16'h0000, "u", 1'b0);
      send_text(16'o100777, "u");
      send_text(16'o100777, ",");
      text_buf = '{"o", "-", 8'h00};
      send_buffer(16'o100777);
      send_text(16'o100700, "u=go");
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int word_budget,
                                      logic [11:0] umask_value);
      int sent;
      logic [15:0] mode;
      drain_results();
      write_umask(umask_value);
      sender_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < word_budget) begin
         if ($urandom_range(99) < 4)
            send_word(KIND_CHAR, 16'($urandom), 8'($urandom), 1'($urandom));
         if ($urandom_range(99) < 4) begin
            send_word(KIND_START, 16'($urandom), 8'($urandom), 1'b0);
            send_word(KIND_CHAR, 16'($urandom), "u", 1'b0);
            sent += 2;
         end
         mode = ($urandom_range(3) == 0) ? (TYPE_DIR | 16'($urandom_range(12'hFFF)))
                                        : 16'($urandom);
         build_random_text();
         send_buffer(mode);
         sent += text_buf.size() + 1;
      end
   endtask

   task automatic test_result_backpressure();
      drain_results();
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      stall_hold_request = 1'b1;
      repeat (30) begin
         send_text(16'($urandom), "7");
         send_text(16'($urandom), "u+x");
      end
   endtask

   initial begin
      ev_umask = UMASK_RESET;
      ev_phase = PH_IDLE;
      ev_mode = '0;
      ev_saved_mode = '0;
      ev_octal = '0;
      ev_who_bits = '0;
      ev_who_named = 1'b0;
      ev_op = OP_NONE;
      ev_perm = '0;
      ev_error = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_octal_strings();
      test_symbolic_strings();
      test_special_cases();
      test_random_traffic(0, 0, 450, UMASK_RESET);
      test_random_traffic(51, 0, 400, 12'o0000);
      test_random_traffic(0, 51, 400, PERM_ALL);
      test_result_backpressure();
      test_random_traffic(23, 23, 400, 12'($urandom));
      drain_results();
      if (mismatch_count == 0)
         $display("file_mode_string_parser_core: match");
      else
         $display("file_mode_string_parser_core: mismatch");
      $finish;
   end

endmodule

>>> files.f
rtl/fmsp_pkg.sv
rtl/fmsp_front.sv
rtl/fmsp_queue.sv
rtl/fmsp_back.sv
rtl/file_mode_string_parser_core.sv
bench/tb_top.sv
